### design/pcdr_pkg.sv
// Shared constants and control types for the pair class renumbering block.
`default_nettype none

package pcdr_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int FIELD_W     = 16;
    localparam int PROD_W      = 2 * FIELD_W;
    localparam int KEY_W       = PROD_W + 1;
    localparam int CLASS_W     = 12;
    localparam int COUNT_W     = 13;
    localparam int EPOCH_W     = 8;
    localparam int ENTRY_W     = EPOCH_W + CLASS_W;

    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};

    localparam logic KIND_BEGIN = 1'b0;
    localparam logic KIND_SITE  = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic clr;      // write one table entry of the clearing pass
        logic capture;  // latch the accepted request
        logic mul;      // register the product
        logic key;      // form key / decide pass, issue table read
        logic load;     // load output registers, commit table write
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_begin;
        logic epoch_wrap;
        logic clr_last;
    } t_sts;

endpackage

`default_nettype wire

### design/pcdr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pcdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### design/pcdr_ctrl.sv
// Controller state machine: clearing pass, request sequencing, output handshake.
`default_nettype none

module pcdr_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    input  wire pcdr_pkg::t_sts i_sts,
    output pcdr_pkg::t_cmd      o_cmd
);

    import pcdr_pkg::*;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_KEY  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    t_cmd       w_cmd;

    always_comb begin
        w_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_CLR: begin
                w_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.capture = 1'b1;
                    n_state       = S_MUL;
                end
            end
            S_MUL: begin
                w_cmd.mul = 1'b1;
                n_state   = S_KEY;
            end
            S_KEY: begin
                w_cmd.key = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                // wait for the output register to be free
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.load = 1'b1;
                    n_state    = (i_sts.is_begin && i_sts.epoch_wrap) ? S_CLR : S_IDLE;
                end
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

    always_comb begin
        if (w_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

endmodule

`default_nettype wire

### design/pcdr_dp.sv
// Datapath: request registers, key multiplier, epoch-tagged class table, results.
`default_nettype none

module pcdr_dp (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire pcdr_pkg::t_cmd                 i_cmd,
    output pcdr_pkg::t_sts                      o_sts,
    input  wire logic                           i_kind,
    input  wire logic [pcdr_pkg::FIELD_W-1:0]   i_left_class,
    input  wire logic [pcdr_pkg::FIELD_W-1:0]   i_right_class,
    input  wire logic [pcdr_pkg::FIELD_W-1:0]   i_left_count,
    input  wire logic [pcdr_pkg::FIELD_W-1:0]   i_right_count,
    input  wire logic [pcdr_pkg::FIELD_W-1:0]   i_site_total,
    input  wire logic                           i_last_site,
    output logic                                o_pass_enabled,
    output logic      [pcdr_pkg::CLASS_W-1:0]   o_parent_class,
    output logic                                o_is_new,
    output logic      [pcdr_pkg::COUNT_W-1:0]   o_class_count,
    output logic                                o_pass_done
);

    import pcdr_pkg::*;

    // captured request
    logic               r_kind;
    logic [FIELD_W-1:0] r_lcls;
    logic [FIELD_W-1:0] r_rcls;
    logic [FIELD_W-1:0] r_lcnt;
    logic [FIELD_W-1:0] r_rcnt;
    logic [FIELD_W-1:0] r_total;
    logic               r_last;

    // pass state
    logic               r_enabled;
    logic [FIELD_W-1:0] r_stride;
    logic [FIELD_W-1:0] r_sites;
    logic [COUNT_W-1:0] r_next;
    logic [EPOCH_W-1:0] r_epoch;
    logic               r_wrap;
    logic [ADDR_W-1:0]  r_clr_addr;

    // per-site working regs
    logic [PROD_W-1:0]  r_prod;
    logic               r_key_ok;
    logic [ADDR_W-1:0]  r_addr;

    // output regs
    logic               r_pass_enabled;
    logic [CLASS_W-1:0] r_parent_class;
    logic               r_is_new;
    logic [COUNT_W-1:0] r_class_count;
    logic               r_pass_done;

    logic [FIELD_W-1:0] w_mul_a;
    logic [FIELD_W-1:0] w_mul_b;
    logic [KEY_W-1:0]   w_key;
    logic [FIELD_W-1:0] w_half;
    logic               w_en_dec;
    logic [ENTRY_W-1:0] w_rdata;
    logic [EPOCH_W-1:0] w_tag;
    logic [CLASS_W-1:0] w_tcls;
    logic               w_hit_ok;
    logic               w_occ;
    logic               w_fresh;
    logic [CLASS_W-1:0] w_cls;
    logic [COUNT_W-1:0] w_next_after;
    logic [COUNT_W-1:0] w_count;
    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr;
    logic [ENTRY_W-1:0] w_wdata;

    assign w_mul_a = (r_kind == KIND_SITE) ? r_rcls   : r_lcnt;
    assign w_mul_b = (r_kind == KIND_SITE) ? r_stride : r_rcnt;

    assign w_key  = KEY_W'(r_lcls) + KEY_W'(r_prod);
    assign w_half = r_total >> 1;
    assign w_en_dec = (r_prod != '0) && (r_prod < PROD_W'(TABLE_DEPTH))
                   && (r_lcnt <= w_half) && (r_rcnt <= w_half);

    assign w_tag    = w_rdata[ENTRY_W-1 -: EPOCH_W];
    assign w_tcls   = w_rdata[CLASS_W-1:0];
    assign w_hit_ok = (r_kind == KIND_SITE) && r_key_ok;
    assign w_occ    = (w_tag == r_epoch);
    assign w_fresh  = w_hit_ok && !w_occ;
    assign w_cls    = !w_hit_ok ? '0 : (w_occ ? w_tcls : r_next[CLASS_W-1:0]);

    assign w_next_after = (w_fresh && (r_next < COUNT_W'(TABLE_DEPTH)))
                        ? r_next + COUNT_W'(1) : r_next;
    assign w_count = ((r_kind == KIND_SITE) && r_last && r_enabled
                      && (FIELD_W'(w_next_after) < r_sites)) ? w_next_after : '0;

    assign w_we    = i_cmd.clr || (i_cmd.load && w_fresh);
    assign w_waddr = i_cmd.clr ? r_clr_addr : r_addr;
    assign w_wdata = i_cmd.clr ? '0 : {r_epoch, r_next[CLASS_W-1:0]};

    pcdr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.key),
        .i_raddr (w_key[ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind  <= i_kind;
            r_lcls  <= i_left_class;
            r_rcls  <= i_right_class;
            r_lcnt  <= i_left_count;
            r_rcnt  <= i_right_count;
            r_total <= i_site_total;
            r_last  <= i_last_site;
        end
        if (i_cmd.mul) begin
            r_prod <= w_mul_a * w_mul_b;
        end
        if (i_cmd.key) begin
            r_addr <= w_key[ADDR_W-1:0];
        end
        if (i_cmd.load) begin
            r_pass_enabled <= r_enabled;
            r_parent_class <= w_cls;
            r_is_new       <= w_fresh;
            r_class_count  <= w_count;
            r_pass_done    <= (r_kind == KIND_SITE) && r_last;
        end
    end

    // pass state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled  <= 1'b0;
            r_stride   <= '0;
            r_sites    <= '0;
            r_next     <= '0;
            r_epoch    <= EPOCH_FIRST;
            r_wrap     <= 1'b0;
            r_key_ok   <= 1'b0;
            r_clr_addr <= '0;
        end else begin
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (i_cmd.key) begin
                if (r_kind == KIND_BEGIN) begin
                    r_enabled <= w_en_dec;
                    r_stride  <= r_lcnt;
                    r_sites   <= r_total;
                    r_next    <= '0;
                    r_key_ok  <= 1'b0;
                    // new epoch empties the table; wrap forces a clearing pass
                    r_wrap    <= (r_epoch == EPOCH_LAST);
                    r_epoch   <= (r_epoch == EPOCH_LAST) ? EPOCH_FIRST
                                                         : r_epoch + EPOCH_W'(1);
                end else begin
                    r_key_ok <= r_enabled && (w_key < KEY_W'(TABLE_DEPTH));
                end
            end
            if (i_cmd.load) begin
                r_next <= w_next_after;
            end
        end
    end

    assign o_sts.is_begin   = (r_kind == KIND_BEGIN);
    assign o_sts.epoch_wrap = r_wrap;
    assign o_sts.clr_last   = (r_clr_addr == {ADDR_W{1'b1}});

    assign o_pass_enabled = r_pass_enabled;
    assign o_parent_class = r_parent_class;
    assign o_is_new       = r_is_new;
    assign o_class_count  = r_class_count;
    assign o_pass_done    = r_pass_done;

endmodule

`default_nettype wire

### design/pair_class_dense_renumber.sv
// Top level of the dense class renumbering block for child class pairs.
`default_nettype none

// Channel   Handshake                 Payload
// -------   -----------------------   -------------------------------------------
// in        i_in_valid / o_in_ready   i_kind, i_left_class, i_right_class,
//                                     i_left_count, i_right_count, i_site_total,
//                                     i_last_site
// out       o_out_valid / i_out_ready o_pass_enabled, o_parent_class, o_is_new,
//                                     o_class_count, o_pass_done
//
// Each request passes in turn through accept, multiply, key/table read, and
// result and table write steps; each site reads the table before writing it.
// No new request is accepted until the last one has left its result step; a
// finished result waits in the output register while the next is accepted.
// After reset a clearing pass writes all 4096 table entries, and no request is
// accepted meanwhile. Table entries carry an 8-bit pass tag, so each begin
// request empties the table at once; every 255th begin request wraps the tag
// and is followed by another clearing pass.
// A stalled output holds the block in its result step until it is taken.

module pair_class_dense_renumber (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic                         i_kind,
    input  wire logic [pcdr_pkg::FIELD_W-1:0] i_left_class,
    input  wire logic [pcdr_pkg::FIELD_W-1:0] i_right_class,
    input  wire logic [pcdr_pkg::FIELD_W-1:0] i_left_count,
    input  wire logic [pcdr_pkg::FIELD_W-1:0] i_right_count,
    input  wire logic [pcdr_pkg::FIELD_W-1:0] i_site_total,
    input  wire logic                         i_last_site,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic                              o_pass_enabled,
    output logic      [pcdr_pkg::CLASS_W-1:0] o_parent_class,
    output logic                              o_is_new,
    output logic      [pcdr_pkg::COUNT_W-1:0] o_class_count,
    output logic                              o_pass_done
);

    import pcdr_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencing and both handshakes
    pcdr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // key arithmetic, class table and result registers
    pcdr_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_kind         (i_kind),
        .i_left_class   (i_left_class),
        .i_right_class  (i_right_class),
        .i_left_count   (i_left_count),
        .i_right_count  (i_right_count),
        .i_site_total   (i_site_total),
        .i_last_site    (i_last_site),
        .o_pass_enabled (o_pass_enabled),
        .o_parent_class (o_parent_class),
        .o_is_new       (o_is_new),
        .o_class_count  (o_class_count),
        .o_pass_done    (o_pass_done)
    );

endmodule

`default_nettype wire
